[design/jacobi_five_point_sweep_macros.svh]
// Assertion helpers for the checker of this block.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef JACOBI_FIVE_POINT_SWEEP_MACROS_SVH
`define JACOBI_FIVE_POINT_SWEEP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define JFPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in this cycle implies the expression in the next cycle.
`define JFPS_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

[design/jfps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jfps_pkg;

    // Default geometry and sample width
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths
    localparam int CFG_W  = 32;  // configuration write data
    localparam int IDX_W  = 2;   // configuration register index
    localparam int GRID_W = 11;  // grid_rows / grid_cols registers
    localparam int OUT_W  = 32;  // new_value
    localparam int POS_W  = 10;  // out_row / out_col
    localparam int CHG_W  = 32;  // max_change and epsilon
    localparam int DIM_W  = 17;  // internal geometry compares, holds up to 131071

    localparam int DIM_MIN = 3;

    typedef logic [IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_GRID_ROWS = 2'd0;
    localparam cfg_index_t REG_GRID_COLS = 2'd1;
    localparam cfg_index_t REG_EPSILON   = 2'd2;

    localparam logic [GRID_W-1:0] GRID_RESET   = 11'd3;
    localparam logic [CHG_W-1:0]  CHANGE_MAX   = {CHG_W{1'b1}};

    // Effective dimension: below three acts as three, above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [GRID_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] w;
        w = DIM_W'(v);
        if (w < DIM_W'(DIM_MIN))
            return DIM_W'(DIM_MIN);
        if (w > hi)
            return hi;
        return w;
    endfunction

endpackage

`default_nettype wire

[design/jacobi_five_point_sweep.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                Payload
// config    cfg_we                   cfg_index, cfg_data
// input     in_valid / in_ready      cell_value
// output    out_valid / out_ready    new_value, out_row, out_col, max_change,
//                                    is_last, converged
//
// One grid cell is taken per cycle while in_ready is high; a result passes stage 1, stage 2 and the output register.
// Throughput is set by the line buffer RAMs: one read and one write port each, and the
// read for the next cell is issued from the next column count so the data waits ready.
// Reset (async, active low) clears counters, bank, pipeline valids and running maximum;
// the line buffers keep whatever they held.
// A stalled output holds its result while two more requests fill the inner stages.

module jacobi_five_point_sweep #(
    parameter int MAX_COLS   = jfps_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = jfps_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = jfps_pkg::DEF_VALUE_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [jfps_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [jfps_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [VALUE_BITS-1:0]   cell_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [jfps_pkg::OUT_W-1:0]   new_value,
    output logic [jfps_pkg::POS_W-1:0]          out_row,
    output logic [jfps_pkg::POS_W-1:0]          out_col,
    output logic [jfps_pkg::CHG_W-1:0]          max_change,
    output logic                                is_last,
    output logic                                converged
);

    import jfps_pkg::*;

    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int SUM_W  = VALUE_BITS + 2;
    localparam int DIF_W  = VALUE_BITS + 1;
    localparam int WIDE_W = DIF_W + CHG_W;
    localparam int NVX_W  = VALUE_BITS + OUT_W;

    // Configuration
    logic [GRID_W-1:0] grid_rows_reg;
    logic [GRID_W-1:0] grid_cols_reg;
    logic [CHG_W-1:0]  epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
            epsilon_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_W-1:0];
                REG_EPSILON:   epsilon_reg   <= cfg_data[CHG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;
    logic [DIM_W-1:0] rows_m1;
    logic [DIM_W-1:0] cols_m1;
    logic [DIM_W-1:0] cols_m2;

    assign rows_eff = clamp_dim(grid_rows_reg, DIM_W'(MAX_ROWS));
    assign cols_eff = clamp_dim(grid_cols_reg, DIM_W'(MAX_COLS));
    assign rows_m1  = rows_eff - DIM_W'(1);
    assign cols_m1  = cols_eff - DIM_W'(1);
    assign cols_m2  = cols_eff - DIM_W'(2);

    // Position of the incoming cell
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          bank_reg;
    logic          bank_next;

    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] col_ext;
    logic             end_row;
    logic             end_sweep;
    logic             interior;
    logic             last_cell;
    logic             accept;

    assign row_ext   = DIM_W'(row_reg);
    assign col_ext   = DIM_W'(col_reg);
    assign end_row   = col_ext >= cols_m1;
    assign end_sweep = end_row && (row_ext >= rows_m1);
    assign interior  = (row_ext >= DIM_W'(2)) && (row_ext <= rows_m1)
                    && (col_ext >= DIM_W'(1)) && (col_ext <= cols_m2);
    assign last_cell = (row_ext == rows_m1) && (col_ext == cols_m2);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (end_sweep)
            begin
                row_next  = '0;
                col_next  = '0;
                bank_next = 1'b0;
            end
            else if (end_row)
            begin
                row_next  = row_reg + 1'b1;
                col_next  = '0;
                bank_next = ~bank_reg;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            bank_reg <= bank_next;
        end
    end

    // Line buffers: the bank bit picks which RAM holds the upper row.
    // Upper RAM is read at the column, middle RAM one column ahead.
    logic [CW-1:0]         col_succ;
    logic [CW-1:0]         raddr0;
    logic [CW-1:0]         raddr1;
    logic [VALUE_BITS-1:0] q0;
    logic [VALUE_BITS-1:0] q1;
    logic                  we0;
    logic                  we1;

    assign col_succ = (col_next == CW'(MAX_COLS - 1)) ? '0 : col_next + 1'b1;
    assign raddr0   = bank_next ? col_succ : col_next;
    assign raddr1   = bank_next ? col_next : col_succ;
    assign we0      = accept && !bank_reg;
    assign we1      = accept && bank_reg;

    jfps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_COLS)
    ) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (col_reg),
        .wdata (cell_value),
        .raddr (raddr0),
        .rdata (q0)
    );

    jfps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_COLS)
    ) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (col_reg),
        .wdata (cell_value),
        .raddr (raddr1),
        .rdata (q1)
    );

    logic signed [VALUE_BITS-1:0] north;
    logic signed [VALUE_BITS-1:0] east;

    assign north = bank_reg ? q1 : q0;
    assign east  = bank_reg ? q0 : q1;

    // West/centre window over the middle row; head holds column zero of the
    // row being written, which becomes the middle row's first entry.
    logic signed [VALUE_BITS-1:0] west_reg;
    logic signed [VALUE_BITS-1:0] centre_reg;
    logic signed [VALUE_BITS-1:0] head_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (col_reg == '0)
            begin
                head_reg <= cell_value;
            end
            if (end_row)
            begin
                centre_reg <= head_reg;
            end
            else
            begin
                west_reg   <= centre_reg;
                centre_reg <= east;
            end
        end
    end

    // Stage 1: captured stencil
    logic                         s1_vld_reg;
    logic                         s1_prod_reg;
    logic                         s1_last_reg;
    logic signed [VALUE_BITS-1:0] s1_north_reg;
    logic signed [VALUE_BITS-1:0] s1_south_reg;
    logic signed [VALUE_BITS-1:0] s1_west_reg;
    logic signed [VALUE_BITS-1:0] s1_east_reg;
    logic signed [VALUE_BITS-1:0] s1_centre_reg;
    logic [POS_W-1:0]             s1_row_reg;
    logic [POS_W-1:0]             s1_col_reg;
    logic                         s1_take;

    // Stage 2: new value and clipped change
    logic                         s2_vld_reg;
    logic                         s2_prod_reg;
    logic                         s2_last_reg;
    logic signed [OUT_W-1:0]      s2_new_reg;
    logic [CHG_W-1:0]             s2_ad_reg;
    logic [POS_W-1:0]             s2_row_reg;
    logic [POS_W-1:0]             s2_col_reg;
    logic                         s2_take;

    // Output stage
    logic                         out_valid_reg;
    logic                         out_free;
    logic [CHG_W-1:0]             running_max_reg;
    logic [CHG_W-1:0]             max_next;
    logic signed [OUT_W-1:0]      new_value_reg;
    logic [POS_W-1:0]             out_row_reg;
    logic [POS_W-1:0]             out_col_reg;
    logic [CHG_W-1:0]             max_change_reg;
    logic                         is_last_reg;
    logic                         converged_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_take  = s2_vld_reg && (!s2_prod_reg || out_free);
    assign s1_take  = s1_vld_reg && (!s2_vld_reg || s2_take);
    assign in_ready = !s1_vld_reg || s1_take;

    // Stage 1 carries results and the end-of-sweep marker that clears the maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_prod_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_vld_reg  <= accept && (interior || end_sweep);
            s1_prod_reg <= interior;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg   <= last_cell;
            s1_north_reg  <= north;
            s1_south_reg  <= cell_value;
            s1_west_reg   <= west_reg;
            s1_east_reg   <= east;
            s1_centre_reg <= centre_reg;
            s1_row_reg    <= POS_W'(row_reg - 1'b1);
            s1_col_reg    <= POS_W'(col_reg);
        end
    end

    logic signed [SUM_W-1:0]      sum;
    logic signed [VALUE_BITS-1:0] nv;
    logic signed [NVX_W-1:0]      nv_ext;
    logic signed [DIF_W-1:0]      diff;
    logic [DIF_W-1:0]             abs_diff;
    logic [WIDE_W-1:0]            abs_wide;
    logic [CHG_W-1:0]             abs_sat;

    assign sum      = SUM_W'(s1_north_reg) + SUM_W'(s1_south_reg)
                    + SUM_W'(s1_west_reg) + SUM_W'(s1_east_reg);
    // floor(sum / 4): drop the two low bits
    assign nv       = sum[SUM_W-1:2];
    assign nv_ext   = NVX_W'(nv);
    assign diff     = DIF_W'(nv) - DIF_W'(s1_centre_reg);
    assign abs_diff = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
    assign abs_wide = WIDE_W'(abs_diff);
    assign abs_sat  = (abs_wide > WIDE_W'(CHANGE_MAX)) ? CHANGE_MAX : abs_wide[CHG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            s2_prod_reg <= 1'b0;
        end
        else if (!s2_vld_reg || s2_take)
        begin
            s2_vld_reg  <= s1_take;
            s2_prod_reg <= s1_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s2_last_reg <= s1_last_reg;
            s2_new_reg  <= nv_ext[OUT_W-1:0];
            s2_ad_reg   <= abs_sat;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    assign max_next = (s2_ad_reg > running_max_reg) ? s2_ad_reg : running_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            running_max_reg <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s2_vld_reg && s2_prod_reg;
            end
            if (s2_take)
            begin
                // end-of-sweep marker drops the maximum for the next pass
                running_max_reg <= s2_prod_reg ? max_next : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s2_prod_reg)
        begin
            new_value_reg  <= s2_new_reg;
            out_row_reg    <= s2_row_reg;
            out_col_reg    <= s2_col_reg;
            max_change_reg <= max_next;
            is_last_reg    <= s2_last_reg;
            converged_reg  <= s2_last_reg && (max_next < epsilon_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_value  = new_value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign max_change = max_change_reg;
    assign is_last    = is_last_reg;
    assign converged  = converged_reg;

endmodule

`default_nettype wire

[design/jfps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module jfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/jfps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "jacobi_five_point_sweep_macros.svh"

module jfps_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [jfps_pkg::OUT_W-1:0] new_value,
    input wire logic [jfps_pkg::POS_W-1:0]     out_row,
    input wire logic [jfps_pkg::POS_W-1:0]     out_col,
    input wire logic [jfps_pkg::CHG_W-1:0]     max_change,
    input wire logic                           is_last,
    input wire logic                           converged
);

    import jfps_pkg::*;

    // A stalled result holds its payload
    `JFPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_value) && $stable(out_row) && $stable(out_col) && $stable(max_change) && $stable(is_last), "stalled result changed")

    // Convergence is only reported on the last interior cell
    `JFPS_ASSERT(a_conv_last, (out_valid && converged) |-> is_last, "converged set on a result that is not last")

    // With the output side empty the pipeline must take a request
    `JFPS_ASSERT(a_ready_drained, !out_valid |-> in_ready, "input blocked while output is empty")

endmodule

bind jacobi_five_point_sweep jfps_checker u_jfps_checker (.*);

`default_nettype wire

[bench/tb_jacobi_five_point_sweep.sv]
`timescale 1ns / 1ps

module tb_jacobi_five_point_sweep;
    import jfps_pkg::*;

    localparam int LINE_DEPTH     = DEF_MAX_COLS;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_TARGET  = 500;
    localparam int QUIET_ITEMS    = 200;
    localparam int PARTIAL_RUNS   = 6;
    localparam int PREFILL_COLS   = 41;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int REPORT_CAP     = 200;

    localparam logic signed [31:0] CELL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CELL_MIN = 32'sh8000_0000;

    typedef enum int {FILL_RANDOM, FILL_SMALL, FILL_EXTREME, FILL_FLAT} fill_mode_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [9:0]         row;
        logic [9:0]         col;
        logic [31:0]        peak;
        logic               last;
        logic               conv;
    } relaxed_cell_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [31:0]      cell_value;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] new_value;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic [CHG_W-1:0]        max_change;
    logic                    is_last;
    logic                    converged;

    // predictor state
    logic signed [31:0] line_a [LINE_DEPTH];
    logic signed [31:0] line_b [LINE_DEPTH];
    bit                 line_bank;
    int unsigned        sweep_row;
    int unsigned        sweep_col;
    logic [31:0]        running_peak;
    logic [GRID_W-1:0]  grid_rows_reg;
    logic [GRID_W-1:0]  grid_cols_reg;
    logic [31:0]        epsilon_reg;

    relaxed_cell_t      expected_cells[$];
    relaxed_cell_t      head_cell;
    int                 fail_count;
    int                 random_items;
    bit                 idle_on;
    logic signed [31:0] flat_level;
    int                 holds_requested;
    int                 holds_done;

    jacobi_five_point_sweep dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_value  (new_value),
        .out_row    (out_row),
        .out_col    (out_col),
        .max_change (max_change),
        .is_last    (is_last),
        .converged  (converged)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_dim(input logic [GRID_W-1:0] v, input int unsigned hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        return (v > hi) ? hi : v;
    endfunction

    // Row two above the incoming one, and the row directly above it
    function automatic logic signed [31:0] older_row(input int unsigned idx);
        return line_bank ? line_b[idx] : line_a[idx];
    endfunction

    function automatic logic signed [31:0] newer_row(input int unsigned idx);
        return line_bank ? line_a[idx] : line_b[idx];
    endfunction

    task automatic relax_cell(input logic signed [31:0] sample);
        int unsigned   rows;
        int unsigned   cols;
        int unsigned   r;
        int unsigned   c;
        int unsigned   ci;
        bit            end_row;
        bit            end_sweep;
        longint        north;
        longint        south;
        longint        west;
        longint        east;
        longint        centre;
        longint        total;
        longint        updated;
        longint        delta;
        longint unsigned mag;
        relaxed_cell_t res;
        rows = eff_dim(grid_rows_reg, DEF_MAX_ROWS);
        cols = eff_dim(grid_cols_reg, DEF_MAX_COLS);
        r = sweep_row;
        c = sweep_col;
        ci = c % LINE_DEPTH;
        end_row = (c >= cols - 1);
        end_sweep = end_row && (r >= rows - 1);
        if (r >= 2 && r <= rows - 1 && c >= 1 && c <= cols - 2)
        begin
            north = longint'(older_row(ci));
            west = longint'(newer_row((ci - 1) % LINE_DEPTH));
            centre = longint'(newer_row(ci));
            east = longint'(newer_row((ci + 1) % LINE_DEPTH));
            south = longint'(sample);
            total = north + south + west + east;
            updated = total >>> 2;
            delta = updated - centre;
            mag = (delta < 0) ? -delta : delta;
            if (mag > 64'(CHANGE_MAX))
                mag = 64'(CHANGE_MAX);
            if (mag > running_peak)
                running_peak = mag[31:0];
            res.value = updated[31:0];
            res.row = 10'(r - 1);
            res.col = 10'(c);
            res.peak = running_peak;
            res.last = (r == rows - 1) && (c == cols - 2);
            res.conv = res.last && (running_peak < epsilon_reg);
            expected_cells.push_back(res);
        end
        // overwrite the upper entry after it has been read
        if (line_bank)
            line_b[ci] = sample;
        else
            line_a[ci] = sample;
        if (end_sweep)
        begin
            sweep_row = 0;
            sweep_col = 0;
            running_peak = '0;
            line_bank = 1'b0;
        end
        else if (end_row)
        begin
            sweep_row = r + 1;
            sweep_col = 0;
            line_bank = ~line_bank;
        end
        else
        begin
            sweep_col = c + 1;
        end
    endtask

    task automatic send_cell(input logic signed [31:0] v);
        bit taken;
        while (idle_on && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_value <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_ready === 1'b1);
            if (taken)
                relax_cell(v);
            @(posedge clk);
        end
    endtask

    task automatic await_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        // boundary cells may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_geometry(input logic [31:0] rows, input logic [31:0] cols,
                                    input logic [31:0] eps);
        cfg_we <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data <= rows;
        grid_rows_reg = rows[GRID_W-1:0];
        @(posedge clk);
        cfg_index <= REG_GRID_COLS;
        cfg_data <= cols;
        grid_cols_reg = cols[GRID_W-1:0];
        @(posedge clk);
        cfg_index <= REG_EPSILON;
        cfg_data <= eps;
        epsilon_reg = eps;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_cell(input fill_mode_t mode);
        case (mode)
            FILL_RANDOM:  return $urandom;
            FILL_SMALL:   return int'($urandom_range(0, 2048)) - 1024;
            FILL_EXTREME:
                case ($urandom_range(4))
                    0:       return CELL_MAX;
                    1:       return CELL_MIN;
                    2:       return 0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            default:      return flat_level + int'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [GRID_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return GRID_W'($urandom_range(0, 2));
            1, 2:    return GRID_W'(3);
            3:       return GRID_W'($urandom_range(20, 40));
            default: return GRID_W'($urandom_range(4, 12));
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold(input fill_mode_t mode);
        if (mode == FILL_FLAT)
            return $urandom_range(0, 12);
        case ($urandom_range(3))
            0:       return '0;
            1:       return CHANGE_MAX;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic int sweep_cells();
        return eff_dim(grid_rows_reg, DEF_MAX_ROWS) * eff_dim(grid_cols_reg, DEF_MAX_COLS);
    endfunction

    task automatic stream_sweep(input fill_mode_t mode);
        int n;
        n = sweep_cells();
        for (int i = 0; i < n; i++)
            send_cell(pick_cell(mode));
    endtask

    // 3x3 grid: north neighbour, the other three neighbours, centre, four corners
    task automatic send_cross(input logic signed [31:0] corner, input logic signed [31:0] north,
                              input logic signed [31:0] side, input logic signed [31:0] centre);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                send_cell(centre);
            else if (i == 1)
                send_cell(north);
            else if (i % 2 == 1)
                send_cell(side);
            else
                send_cell(corner);
        end
    endtask

    task automatic test_reset_geometry_extremes();
        // reset geometry is 3x3 with zero threshold; largest possible change
        send_cross(CELL_MIN, CELL_MAX, CELL_MAX, CELL_MIN);
        await_results_drained();
    endtask

    task automatic test_threshold_boundary();
        // change equal to threshold: not converged
        program_geometry(3, 3, CHANGE_MAX);
        send_cross(CELL_MAX, CELL_MIN, CELL_MIN, CELL_MAX);
        await_results_drained();
        // negative sum floors downward; change 99 below 101
        program_geometry(3, 3, 101);
        send_cross(0, -1, 0, -100);
        await_results_drained();
    endtask

    task automatic test_geometry_clamp();
        // rows below three; this sweep also fills both line buffers through column 40
        program_geometry(0, PREFILL_COLS, $urandom);
        stream_sweep(FILL_RANDOM);
        await_results_drained();
        program_geometry(12, 2, $urandom);
        stream_sweep(FILL_SMALL);
        await_results_drained();
    endtask

    task automatic test_output_hold_off();
        program_geometry(5, 12, $urandom);
        holds_requested++;
        stream_sweep(FILL_RANDOM);
        await_results_drained();
    endtask

    task automatic test_random_sweeps();
        fill_mode_t   mode;
        logic [31:0]  rows;
        logic [31:0]  cols;
        bit           first;
        first = 1'b1;
        idle_on = 1'b0;
        random_items = 0;
        while (random_items < RANDOM_TARGET)
        begin
            if (random_items >= QUIET_ITEMS)
                idle_on = 1'b1;
            mode = fill_mode_t'($urandom_range(3));
            flat_level = $urandom;
            // otherwise re-stream straight away under the same setting
            if (first || $urandom_range(3) != 0)
            begin
                await_results_drained();
                rows = 32'(pick_dim());
                cols = 32'(pick_dim());
                if ($urandom_range(3) == 0)
                    rows = rows | ($urandom << GRID_W);
                if ($urandom_range(3) == 0)
                    cols = cols | ($urandom << GRID_W);
                program_geometry(rows, cols, pick_threshold(mode));
                first = 1'b0;
            end
            random_items += sweep_cells();
            stream_sweep(mode);
        end
        await_results_drained();
    endtask

    // change geometry mid-sweep; every line buffer column up to 40 has been written by now
    task automatic test_partial_sweeps();
        int n;
        repeat (PARTIAL_RUNS)
        begin
            program_geometry(32'(pick_dim()), 32'(pick_dim()), pick_threshold(FILL_RANDOM));
            n = $urandom_range(1, sweep_cells() + eff_dim(grid_cols_reg, DEF_MAX_COLS));
            repeat (n) send_cell(pick_cell(fill_mode_t'($urandom_range(2))));
            await_results_drained();
        end
    endtask

    task automatic finish_run();
        await_results_drained();
        if (fail_count == 0)
            $display("jacobi_five_point_sweep verification clean");
        else
            $display("jacobi_five_point_sweep verification failed");
        $finish;
    endtask

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        fail_count++;
        // keep the log bounded on a badly broken build
        if (fail_count <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_requested != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                holds_done++;
            end
            out_ready <= !(idle_on && $urandom_range(99) < 32);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_cells.size() == 0)
            begin
                flag_mismatch("unexpected result, out_row", -1, out_row);
            end
            else
            begin
                head_cell = expected_cells.pop_front();
                if (new_value !== head_cell.value)
                    flag_mismatch("new_value", head_cell.value, new_value);
                if (out_row !== head_cell.row)
                    flag_mismatch("out_row", head_cell.row, out_row);
                if (out_col !== head_cell.col)
                    flag_mismatch("out_col", head_cell.col, out_col);
                if (max_change !== head_cell.peak)
                    flag_mismatch("max_change", head_cell.peak, max_change);
                if (is_last !== head_cell.last)
                    flag_mismatch("is_last", head_cell.last, is_last);
                if (converged !== head_cell.conv)
                    flag_mismatch("converged", head_cell.conv, converged);
            end
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("jacobi_five_point_sweep verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_ROWS;
        cfg_data = '0;
        in_valid = 1'b0;
        cell_value = '0;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            line_a[i] = '0;
            line_b[i] = '0;
        end
        line_bank = 1'b0;
        sweep_row = 0;
        sweep_col = 0;
        running_peak = '0;
        grid_rows_reg = GRID_RESET;
        grid_cols_reg = GRID_RESET;
        epsilon_reg = '0;
        fail_count = 0;
        random_items = 0;
        idle_on = 1'b1;
        flat_level = '0;
        holds_requested = 0;
        holds_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry_extremes();
        test_threshold_boundary();
        test_geometry_clamp();
        test_output_hold_off();
        test_random_sweeps();
        test_partial_sweeps();
        finish_run();
    end

endmodule
